// ===== design/dltq_pkg.sv =====
// dltq_pkg: shared types and constants of the delta-list timer queue
// used by the controller, the datapath, the top level and the checker
`timescale 1ns / 1ps

package dltq_pkg;

  // default number of timer slots
  localparam int DLTQ_DEPTH = 16;

  // width of the pending field of a result
  localparam int PEND_W = 5;

  // request opcodes; the fourth code leaves the list unchanged and gets one empty result
  typedef enum logic [1:0] {
    OP_SCHEDULE = 2'd0,
    OP_CANCEL   = 2'd1,
    OP_ADVANCE  = 2'd2
  } op_t;

  // result status codes
  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FULL = 1'b1;

  // one timer as stored in the list
  typedef struct packed {
    logic [31:0] delta;
    logic [7:0]  owner;
    logic [7:0]  id;
  } entry_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_PRIME,
    S_WALK,
    S_FINISH
  } ctrl_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic walk;
    logic finish;
  } ctl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic item_pass;
    logic at_end;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== design/dltq_if.sv =====
// dltq_if: request and result channel interfaces of the timer queue
// valid/ready handshake with the payload fields; no dependencies
`timescale 1ns / 1ps

interface dltq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] delay;
  logic [7:0]  owner;
  logic [7:0]  timer_id;
  logic [15:0] ticks;

  modport source (output valid, op, delay, owner, timer_id, ticks, input ready);
  modport sink   (input valid, op, delay, owner, timer_id, ticks, output ready);
endinterface

interface dltq_out_if;
  logic        valid;
  logic        ready;
  logic        fired;
  logic [7:0]  fired_owner;
  logic [7:0]  fired_id;
  logic [15:0] late_by;
  logic        status;
  logic [4:0]  pending;
  logic        last;

  modport source (output valid, fired, fired_owner, fired_id, late_by, status, pending,
                  last, input ready);
  modport sink   (input valid, fired, fired_owner, fired_id, late_by, status, pending,
                  last, output ready);
endinterface

// ===== design/delta_list_timer_queue_core.sv =====
// Delta-list timer queue: up to DEPTH timers kept in deadline order as deltas.
// Channels: in_ch carries requests (op 0 schedule, 1 cancel, 2 advance) with
// delay, owner, timer_id and ticks; out_ch returns results with fired,
// fired_owner, fired_id, late_by, status, pending and last.
// Each schedule into a non-full queue, cancel or advance walks the stored
// list once, copying it entry by entry from one RAM bank into the other,
// one entry per cycle unless an advance is held for the output; the RAM
// read port sets the pace. A full-queue schedule and an unknown op skip
// the walk. Schedule and cancel give one result, an advance gives one
// result per expired timer, or one empty result, with last set on the
// final one. A new request is taken only after the previous request has
// put its final result into the output register; that register is free
// again when out_ch.ready takes it, so a stalled receiver holds the walk
// of an advance at the next expired timer.
// Reset (rst, synchronous) empties the queue; no clearing pass is needed.
// Depends on dltq_pkg, dltq_if, dltq_ctrl and dltq_dp.
`timescale 1ns / 1ps

module delta_list_timer_queue_core import dltq_pkg::*; #(
  parameter int DEPTH = DLTQ_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  dltq_in_if.sink    in_ch,
  dltq_out_if.source out_ch
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // sequencer
  dltq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // list storage and arithmetic
  dltq_dp #(.DEPTH(DEPTH)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_op       (in_ch.op),
    .in_delay    (in_ch.delay),
    .in_owner    (in_ch.owner),
    .in_timer_id (in_ch.timer_id),
    .in_ticks    (in_ch.ticks),
    .cmd         (cmd),
    .stat        (stat),
    .out_ch      (out_ch)
  );

endmodule

// ===== design/dltq_ram.sv =====
// dltq_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`timescale 1ns / 1ps

module dltq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/dltq_ctrl.sv =====
// dltq_ctrl: sequencer of the timer queue, one request at a time
// depends on dltq_pkg for the state, command and status types
`timescale 1ns / 1ps

module dltq_ctrl import dltq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  ctrl_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = stat.item_pass ? S_PRIME : S_FINISH;
        end
      end
      S_PRIME: begin
        // first list entry is being read
        state_next = S_WALK;
      end
      S_WALK: begin
        if (stat.at_end) begin
          state_next = S_FINISH;
        end else begin
          cmd.walk = 1'b1;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/dltq_dp.sv =====
// dltq_dp: list storage in two ping-pong RAM banks, walk arithmetic and result register
// depends on dltq_pkg, dltq_if and dltq_ram
`timescale 1ns / 1ps

module dltq_dp import dltq_pkg::*; #(
  parameter int DEPTH = DLTQ_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        in_op,
  input  logic [31:0]       in_delay,
  input  logic [7:0]        in_owner,
  input  logic [7:0]        in_timer_id,
  input  logic [15:0]       in_ticks,
  input  ctl_cmd_t          cmd,
  output dp_stat_t          stat,
  dltq_out_if.source        out_ch
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int EW = $bits(entry_t);

  // list bookkeeping
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] w;
  logic          bank;

  // latched request
  logic [1:0]    op_q;
  logic          full_q;
  logic          pass_q;
  logic [7:0]    own_q;
  logic [7:0]    id_q;

  // walk state
  logic          flag;
  logic [31:0]   rem;
  logic [31:0]   acc;
  logic [15:0]   t;

  // fired timer waiting for its last mark
  logic          hold_valid;
  logic [7:0]    hold_owner;
  logic [7:0]    hold_id;
  logic [15:0]   hold_late;
  logic [CW-1:0] hold_pending;

  // result register
  logic          out_valid;
  logic          out_fired;
  logic [7:0]    out_owner;
  logic [7:0]    out_id;
  logic [15:0]   out_late;
  logic          out_status;
  logic [PEND_W-1:0] out_pending;
  logic          out_last;

  // RAM ports
  logic [EW-1:0] rd0, rd1;
  logic          wr;
  entry_t        wdata;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  entry_t        d;

  // walk decode
  logic          idx_adv;
  logic          ins_now;
  logic          fire_now;
  logic          is_match;
  logic          fire;
  logic          out_free;
  logic          append;
  logic [CW-1:0] cnt_fin;
  logic [CW-1:0] idx_inc;

  assign d        = entry_t'(bank ? rd1 : rd0);
  assign is_match = (d.owner == own_q) && (d.id == id_q);
  assign fire     = d.delta <= {16'd0, t};
  assign out_free = !out_valid || out_ch.ready;
  assign idx_inc  = idx + 1'b1;
  assign append   = pass_q && (op_q == OP_SCHEDULE) && !flag;
  assign cnt_fin  = pass_q ? (append ? w + 1'b1 : w) : count;

  // status to the controller
  assign stat.item_pass = ((in_op == OP_SCHEDULE) && (count != CW'(DEPTH)))
                        || (in_op == OP_CANCEL) || (in_op == OP_ADVANCE);
  assign stat.at_end    = idx == count;
  assign stat.out_free  = out_free;

  // per-entry decisions of the list walk
  always_comb begin
    wr       = 1'b0;
    wdata    = d;
    idx_adv  = 1'b0;
    ins_now  = 1'b0;
    fire_now = 1'b0;
    if (cmd.walk) begin
      case (op_q)
        OP_SCHEDULE: begin
          wr = 1'b1;
          if (!flag && (rem < d.delta)) begin
            // new timer goes in front of this entry, entry is re-read
            wdata   = '{delta: rem, owner: own_q, id: id_q};
            ins_now = 1'b1;
          end else begin
            idx_adv = 1'b1;
            if (flag) begin
              wdata.delta = d.delta - acc;
            end
          end
        end
        OP_CANCEL: begin
          idx_adv = 1'b1;
          if (!is_match) begin
            wr          = 1'b1;
            wdata.delta = d.delta + acc;
          end
        end
        OP_ADVANCE: begin
          if (!flag && fire) begin
            // a fired timer may move only when the held one can leave
            if (!hold_valid || out_free) begin
              fire_now = 1'b1;
              idx_adv  = 1'b1;
            end
          end else begin
            wr      = 1'b1;
            idx_adv = 1'b1;
            if (!flag) begin
              wdata.delta = d.delta - {16'd0, t};
            end
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.finish && append) begin
      // timer belongs behind every entry
      wr    = 1'b1;
      wdata = '{delta: rem, owner: own_q, id: id_q};
    end
  end

  assign raddr = idx_adv ? idx_inc[AW-1:0] : idx[AW-1:0];
  assign waddr = w[AW-1:0];

  // ping-pong banks: read the current one, write the other
  dltq_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_bank0 (
    .clk   (clk),
    .we    (wr && bank),
    .waddr (waddr),
    .wdata (EW'(wdata)),
    .raddr (raddr),
    .rdata (rd0)
  );

  dltq_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_bank1 (
    .clk   (clk),
    .we    (wr && !bank),
    .waddr (waddr),
    .wdata (EW'(wdata)),
    .raddr (raddr),
    .rdata (rd1)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      bank       <= 1'b0;
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      // result register fills on a released fired timer or at the finish
      if (cmd.finish || (fire_now && hold_valid)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.load) begin
        hold_valid <= 1'b0;
      end
      if (fire_now) begin
        hold_valid <= 1'b1;
      end
      if (cmd.finish) begin
        hold_valid <= 1'b0;
        count      <= cnt_fin;
        bank       <= bank ^ pass_q;
      end
    end
  end

  // request latch and walk registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= in_op;
      full_q <= (in_op == OP_SCHEDULE) && (count == CW'(DEPTH));
      pass_q <= stat.item_pass;
      own_q  <= in_owner;
      id_q   <= in_timer_id;
      rem    <= in_delay;
      t      <= in_ticks;
      acc    <= '0;
      flag   <= 1'b0;
      idx    <= '0;
      w      <= '0;
    end else if (cmd.walk) begin
      if (wr) begin
        w <= w + 1'b1;
      end
      if (idx_adv) begin
        idx <= idx_inc;
      end
      case (op_q)
        OP_SCHEDULE: begin
          if (ins_now) begin
            flag <= 1'b1;
            acc  <= rem;
          end else if (flag) begin
            acc <= '0;
          end else begin
            rem <= rem - d.delta;
          end
        end
        OP_CANCEL: begin
          acc <= is_match ? acc + d.delta : '0;
        end
        OP_ADVANCE: begin
          if (fire_now) begin
            t <= t - d.delta[15:0];
          end else if (!flag && !fire) begin
            flag <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // held fired timer
  always_ff @(posedge clk) begin
    if (fire_now) begin
      hold_owner   <= d.owner;
      hold_id      <= d.id;
      hold_late    <= t - d.delta[15:0];
      hold_pending <= count - idx_inc;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (fire_now && hold_valid) begin
      out_fired   <= 1'b1;
      out_owner   <= hold_owner;
      out_id      <= hold_id;
      out_late    <= hold_late;
      out_status  <= ST_OK;
      out_pending <= PEND_W'(hold_pending);
      out_last    <= 1'b0;
    end else if (cmd.finish) begin
      out_last <= 1'b1;
      if (hold_valid) begin
        out_fired   <= 1'b1;
        out_owner   <= hold_owner;
        out_id      <= hold_id;
        out_late    <= hold_late;
        out_status  <= ST_OK;
        out_pending <= PEND_W'(hold_pending);
      end else begin
        out_fired   <= 1'b0;
        out_owner   <= '0;
        out_id      <= '0;
        out_late    <= '0;
        out_status  <= full_q ? ST_FULL : ST_OK;
        out_pending <= PEND_W'(cnt_fin);
      end
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.fired       = out_fired;
  assign out_ch.fired_owner = out_owner;
  assign out_ch.fired_id    = out_id;
  assign out_ch.late_by     = out_late;
  assign out_ch.status      = out_status;
  assign out_ch.pending     = out_pending;
  assign out_ch.last        = out_last;

endmodule

// ===== design/dltq_checker.sv =====
// dltq_checker: port-level assertions of the timer queue, bound to the top level
// depends on dltq_pkg and delta_list_timer_queue_core
`timescale 1ns / 1ps

module dltq_checker import dltq_pkg::*; #(
  parameter int DEPTH = DLTQ_DEPTH
) (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        fired,
  input logic [7:0]  fired_owner,
  input logic [7:0]  fired_id,
  input logic [15:0] late_by,
  input logic        status,
  input logic [4:0]  pending,
  input logic        last
);

  // one request at a time: ready drops right after a request is taken
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while previous one still in work");

  // an empty result always closes the request
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !fired) |-> last)
    else $error("result without a fired timer is not marked last");

  // a fired timer never reports a dropped schedule
  a_fired_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && fired) |-> !status)
    else $error("fired result carries full status");

  // pending never exceeds the queue size
  a_pending_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pending <= DEPTH))
    else $error("pending count above depth");

  // stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(fired) && $stable(fired_owner)
      && $stable(fired_id) && $stable(late_by) && $stable(status)
      && $stable(pending) && $stable(last)))
    else $error("stalled result changed");

endmodule

bind delta_list_timer_queue_core dltq_checker #(.DEPTH(DEPTH)) u_dltq_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .fired       (out_ch.fired),
  .fired_owner (out_ch.fired_owner),
  .fired_id    (out_ch.fired_id),
  .late_by     (out_ch.late_by),
  .status      (out_ch.status),
  .pending     (out_ch.pending),
  .last        (out_ch.last)
);
